// File: src/mmdo_pkg.sv
// Package: beat types, region codes and address decode for the memory map decoder.
package mmdo_pkg;

  localparam int unsigned DmaBytesDef      = 160;
  localparam int unsigned CyclesPerByteDef = 4;
  localparam int unsigned RomBytesDef      = 32768;

  localparam logic [2:0] KIND_RD_BYTE  = 3'd0;
  localparam logic [2:0] KIND_RD_WORD  = 3'd1;
  localparam logic [2:0] KIND_WR_BYTE  = 3'd2;
  localparam logic [2:0] KIND_WR_WORD  = 3'd3;
  localparam logic [2:0] KIND_DMA      = 3'd4;
  localparam logic [2:0] KIND_TICK     = 3'd5;

  typedef logic [1:0] region_t;
  localparam region_t REG_MEM  = 2'd0;  // plain backing store
  localparam region_t REG_OAM  = 2'd1;
  localparam region_t REG_IO   = 2'd2;
  localparam region_t REG_NONE = 2'd3;  // reads 0, writes dropped

  localparam logic [15:0] OamBase = 16'hFE00;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] addr;
    logic [15:0] wdata;
    logic [15:0] cycles;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] rdata;
    logic        io_req;
    logic        io_is_write;
    logic [6:0]  io_offset;
    logic [7:0]  io_wdata;
    logic        write_dropped;
    logic        dma_busy;
    logic [15:0] dma_sum;
  } out_beat_t;

  typedef struct packed {
    region_t     region;
    logic [15:0] idx;
  } dec_t;

  // Echo folds onto work RAM; every other mapped byte keeps its bus address.
  function automatic dec_t decode(logic [15:0] a, logic [16:0] rom_bytes);
    dec_t d;
    d.idx    = a;
    d.region = REG_MEM;
    if (a < 16'h8000) begin
      if ({1'b0, a} >= rom_bytes) d.region = REG_NONE;
    end else if (a >= 16'hE000 && a < 16'hFE00) begin
      d.idx = a - 16'h2000;
    end else if (a >= 16'hFE00 && a < 16'hFEA0) begin
      d.region = REG_OAM;
    end else if (a >= 16'hFEA0 && a < 16'hFF00) begin
      d.region = REG_NONE;
    end else if (a >= 16'hFF00 && a < 16'hFF80) begin
      d.region = REG_IO;
    end
    return d;
  endfunction

endpackage

// File: src/mmdo_ram.sv
// Single-port 64K x 8 byte store with registered read data.
module mmdo_ram (
  input  logic        clk_i,
  input  logic        we_i,
  input  logic [15:0] addr_i,
  input  logic [7:0]  wdata_i,
  output logic [7:0]  rdata_o
);

  logic [7:0] mem [65536];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/memory_map_decoder_with_oam_dma.sv
// Top level: bus decode sequencer, OAM DMA engine and byte store.
// After reset the store is cleared one byte per cycle, all 65536 bytes, before
// the first item is taken. Items run one at a time. Reads and writes use the
// single-port byte store via ST_BYTE (and ST_BWAIT for reads) per byte, then
// ST_FIN; a DMA start or a tick with no DMA running goes straight to ST_FIN; a
// tick with DMA running passes ST_DCHK, then ST_DWR and ST_DCHK per byte copied
// (one store read, one store write), then ST_FIN. A finished result sits in an
// output register while the next item is accepted; a result still waiting there
// holds the following item in ST_FIN until the output beat is taken.
module memory_map_decoder_with_oam_dma #(
  parameter int unsigned DMA_BYTES       = mmdo_pkg::DmaBytesDef,
  parameter int unsigned CYCLES_PER_BYTE = mmdo_pkg::CyclesPerByteDef,
  parameter int unsigned ROM_BYTES       = mmdo_pkg::RomBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mmdo_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mmdo_pkg::out_beat_t out_beat_o
);

  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_BYTE  = 4'd2;
  localparam logic [3:0] ST_BWAIT = 4'd3;
  localparam logic [3:0] ST_DCHK  = 4'd4;
  localparam logic [3:0] ST_DWR   = 4'd5;
  localparam logic [3:0] ST_FIN   = 4'd6;

  localparam logic [16:0] RomLimit = 17'(ROM_BYTES);
  localparam logic [16:0] Cpb      = 17'(CYCLES_PER_BYTE);
  localparam logic [7:0]  DmaLen   = 8'(DMA_BYTES);

  logic [3:0]  state_q, state_d;
  logic [15:0] clr_q, clr_d;
  mmdo_pkg::in_beat_t item_q, item_d;
  logic        sel_q, sel_d;
  mmdo_pkg::region_t rreg_q, rreg_d;
  mmdo_pkg::out_beat_t res_q, res_d;
  logic        out_vld_q, out_vld_d;
  mmdo_pkg::out_beat_t out_q, out_d;

  logic        dma_active_q, dma_active_d;
  logic [15:0] dma_src_q, dma_src_d;
  logic [7:0]  dma_left_q, dma_left_d;
  logic [16:0] dma_cnt_q, dma_cnt_d;
  logic [15:0] dma_sum_q, dma_sum_d;

  logic        mem_we;
  logic [15:0] mem_addr;
  logic [7:0]  mem_wd, mem_rd;

  logic [15:0]     byte_addr;
  logic [7:0]      byte_wd, rd_byte;
  mmdo_pkg::dec_t  dec, src_dec;
  logic            is_write, is_word;
  logic [7:0]      oam_idx;

  mmdo_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wd),
    .rdata_o (mem_rd)
  );

  assign byte_addr = sel_q ? item_q.addr + 16'd1 : item_q.addr;
  assign byte_wd   = sel_q ? item_q.wdata[15:8] : item_q.wdata[7:0];
  assign dec       = mmdo_pkg::decode(byte_addr, RomLimit);
  assign src_dec   = mmdo_pkg::decode(dma_src_q, RomLimit);
  assign is_write  = (item_q.kind == mmdo_pkg::KIND_WR_BYTE) ||
                     (item_q.kind == mmdo_pkg::KIND_WR_WORD);
  assign is_word   = (item_q.kind == mmdo_pkg::KIND_RD_WORD) ||
                     (item_q.kind == mmdo_pkg::KIND_WR_WORD);
  assign rd_byte   = (rreg_q == mmdo_pkg::REG_MEM || rreg_q == mmdo_pkg::REG_OAM) ?
                     mem_rd : 8'h00;
  assign oam_idx   = DmaLen - dma_left_q;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    item_d       = item_q;
    sel_d        = sel_q;
    rreg_d       = rreg_q;
    res_d        = res_q;
    out_vld_d    = out_vld_q;
    out_d        = out_q;
    dma_active_d = dma_active_q;
    dma_src_d    = dma_src_q;
    dma_left_d   = dma_left_q;
    dma_cnt_d    = dma_cnt_q;
    dma_sum_d    = dma_sum_q;
    mem_we       = 1'b0;
    mem_addr     = dec.idx;
    mem_wd       = byte_wd;

    if (out_vld_q && !out_stall_i) out_vld_d = 1'b0;

    case (state_q)
      ST_CLR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
        mem_wd   = 8'h00;
        clr_d    = clr_q + 16'd1;
        if (clr_q == 16'hFFFF) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d = in_beat_i;
          sel_d  = 1'b0;
          res_d  = '0;
          case (in_beat_i.kind)
            mmdo_pkg::KIND_RD_BYTE, mmdo_pkg::KIND_RD_WORD,
            mmdo_pkg::KIND_WR_BYTE, mmdo_pkg::KIND_WR_WORD: state_d = ST_BYTE;
            mmdo_pkg::KIND_DMA: begin
              if (!dma_active_q) begin
                dma_src_d    = {in_beat_i.wdata[7:0], 8'h00};
                dma_active_d = 1'b1;
                dma_left_d   = DmaLen;
                dma_cnt_d    = '0;
                dma_sum_d    = '0;
              end
              state_d = ST_FIN;
            end
            mmdo_pkg::KIND_TICK: begin
              if (dma_active_q) begin
                dma_cnt_d = dma_cnt_q + {1'b0, in_beat_i.cycles};
                state_d   = ST_DCHK;
              end else begin
                state_d = ST_FIN;
              end
            end
            default: state_d = ST_FIN;
          endcase
        end
      end
      ST_BYTE: begin
        // only the first IO byte of a word is reported
        if (dec.region == mmdo_pkg::REG_IO && !res_q.io_req) begin
          res_d.io_req      = 1'b1;
          res_d.io_is_write = is_write;
          res_d.io_offset   = byte_addr[6:0];
          res_d.io_wdata    = is_write ? byte_wd : 8'h00;
        end
        if (is_write) begin
          case (dec.region)
            mmdo_pkg::REG_MEM: mem_we = 1'b1;
            mmdo_pkg::REG_OAM: begin
              if (dma_active_q) res_d.write_dropped = 1'b1;
              else mem_we = 1'b1;
            end
            mmdo_pkg::REG_NONE: res_d.write_dropped = 1'b1;
            default: ;
          endcase
          if (is_word && !sel_q) sel_d = 1'b1;
          else state_d = ST_FIN;
        end else begin
          rreg_d  = dec.region;
          state_d = ST_BWAIT;
        end
      end
      ST_BWAIT: begin
        if (sel_q) res_d.rdata[15:8] = rd_byte;
        else res_d.rdata[7:0] = rd_byte;
        if (is_word && !sel_q) begin
          sel_d   = 1'b1;
          state_d = ST_BYTE;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_DCHK: begin
        mem_addr = src_dec.idx;
        rreg_d   = (src_dec.region == mmdo_pkg::REG_IO) ? mmdo_pkg::REG_NONE :
                   src_dec.region;
        if (dma_cnt_q >= Cpb && dma_left_q != 8'd0) begin
          state_d = ST_DWR;
        end else begin
          if (dma_left_q == 8'd0) dma_active_d = 1'b0;
          state_d = ST_FIN;
        end
      end
      ST_DWR: begin
        mem_we     = 1'b1;
        mem_addr   = mmdo_pkg::OamBase + {8'h00, oam_idx};
        mem_wd     = rd_byte;
        dma_left_d = dma_left_q - 8'd1;
        dma_cnt_d  = dma_cnt_q - Cpb;
        dma_src_d  = dma_src_q + 16'd1;
        dma_sum_d  = dma_sum_q + {8'h00, rd_byte};
        state_d    = ST_DCHK;
      end
      ST_FIN: begin
        if (!out_vld_q || !out_stall_i) begin
          out_d          = res_q;
          out_d.dma_busy = dma_active_q;
          out_d.dma_sum  = dma_sum_q;
          out_vld_d      = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLR;
      clr_q        <= '0;
      out_vld_q    <= 1'b0;
      dma_active_q <= 1'b0;
      dma_src_q    <= '0;
      dma_left_q   <= '0;
      dma_cnt_q    <= '0;
      dma_sum_q    <= '0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      out_vld_q    <= out_vld_d;
      dma_active_q <= dma_active_d;
      dma_src_q    <= dma_src_d;
      dma_left_q   <= dma_left_d;
      dma_cnt_q    <= dma_cnt_d;
      dma_sum_q    <= dma_sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    sel_q  <= sel_d;
    rreg_q <= rreg_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_beat_o  = out_q;

  a_left_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dma_left_q <= DmaLen)
    else $error("dma byte count above transfer length");

  a_done_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(dma_active_q) |-> dma_left_q == 8'd0)
    else $error("dma ended with bytes left");

  a_sum_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(dma_sum_q) |-> ($past(state_q) == ST_DWR || $past(state_q) == ST_IDLE))
    else $error("dma sum changed outside a copy or start");

endmodule
